// ===== hw/rtl/swlp_pkg.sv =====
// Shared definitions for the sliding-window linear predictor.
// Field widths, saturation limits, sequencer states and divider status.
// No dependencies.
package swlp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PRED_W      = 18;
  localparam int LOOKAHEAD_W = 6;
  localparam int WINDOW_DEF  = 8;

  localparam longint PRED_MAX_VAL = 131071;
  localparam longint PRED_MIN_VAL = -131072;

  localparam logic signed [PRED_W-1:0] PRED_MAX = {1'b0, {(PRED_W-1){1'b1}}};
  localparam logic signed [PRED_W-1:0] PRED_MIN = {1'b1, {(PRED_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_PROD,
    S_DIFF,
    S_SCALE,
    S_SUM,
    S_RANGE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [PRED_W-1:0] quotient;
  } div_status_t;

endpackage

// ===== hw/rtl/swlp_channels.sv =====
// Valid/ready channel interfaces of the sliding-window linear predictor.
// Depends on swlp_pkg for the field widths.
interface swlp_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swlp_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swlp_pred_if;
  logic                                valid;
  logic                                ready;
  logic signed [swlp_pkg::PRED_W-1:0]  prediction;
  modport source (output valid, output prediction, input ready);
  modport sink (input valid, input prediction, output ready);
endinterface

interface swlp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [swlp_pkg::LOOKAHEAD_W-1:0]    lookahead;
  modport source (output valid, output lookahead, input ready);
  modport sink (input valid, input lookahead, output ready);
endinterface

// ===== hw/rtl/sliding_window_linear_predictor.sv =====
// Sliding-window least-squares line predictor. Each accepted sample request
// replaces the oldest entry of a WINDOW-deep sample memory (zero after reset)
// and updates two running sums, the plain sum and the position-weighted sum.
// From those the block fits y = a*x + b over the window (x = 0 oldest,
// x = WINDOW-1 newest) and returns one prediction per sample: the line's
// value at x = WINDOW + lookahead, rounded to nearest (halves up) and
// saturated to 18 bits signed. Timing: one sample at a time. A saturated
// result sits in the output register after the memory update, four product
// stages, the range check and the output load; an in-range one also passes
// the registered reciprocal multiply that forms the quotient. The next
// sample is taken the cycle after the result is loaded, even if the sink
// has not yet taken it; a stalled sink holds the block until the output
// register frees. The user must write lookahead through the config channel
// only while the block is idle; the block does not enforce this. The config
// channel is always ready.
module sliding_window_linear_predictor #(
  parameter int WINDOW = swlp_pkg::WINDOW_DEF
) (
  input logic         clk,
  input logic         rst,
  swlp_sample_if.sink sample_ch,
  swlp_cfg_if.sink    cfg_ch,
  swlp_pred_if.source pred_ch
);

  localparam int SAMPLE_W = swlp_pkg::SAMPLE_W;
  localparam int PRED_W   = swlp_pkg::PRED_W;
  localparam int LA_W     = swlp_pkg::LOOKAHEAD_W;
  localparam int PTR_W    = $clog2(WINDOW);

  // Fit constants: D = W*Sxx - Sx^2, den = 2*W*D.
  localparam longint W        = WINDOW;
  localparam longint SX       = W * (W - 1) / 2;
  localparam longint SXX      = (W - 1) * W * (2 * W - 1) / 6;
  localparam longint DD       = W * SXX - SX * SX;
  localparam longint DEN      = 2 * W * DD;
  localparam longint HALF_DEN = W * DD;
  localparam longint S_MAG    = longint'(1) << (SAMPLE_W - 1);
  localparam longint LA_MAX   = (longint'(1) << LA_W) - 1;
  localparam longint T_MAX    = W + 1 + 2 * LA_MAX;
  localparam longint N_MAX    = 2 * S_MAG * W * SX;
  localparam longint LIM_LO   = swlp_pkg::PRED_MIN_VAL * DEN;
  localparam longint LIM_HI   = (swlp_pkg::PRED_MAX_VAL + 1) * DEN;
  localparam longint NUM_MAG  = 2 * S_MAG * W * DD + W * N_MAX * T_MAX + HALF_DEN + LIM_HI;

  localparam int SY_W  = SAMPLE_W + 1 + $clog2(WINDOW);
  localparam int SXY_W = SAMPLE_W + 1 + $clog2(SX + 1);
  localparam int T_W   = $clog2(T_MAX + 1);
  localparam int N_W   = $clog2(N_MAX + 1) + 1;
  localparam int NUM_W = $clog2(NUM_MAG + 1) + 1;
  localparam int U_W   = PRED_W + $clog2(DEN);

  localparam logic signed [SXY_W-1:0] WM1_C   = SXY_W'(W - 1);
  localparam logic signed [NUM_W-1:0] W_C     = NUM_W'(W);
  localparam logic signed [NUM_W-1:0] SX_C    = NUM_W'(SX);
  localparam logic signed [NUM_W-1:0] D2_C    = NUM_W'(2 * DD);
  localparam logic signed [NUM_W-1:0] HALF_C  = NUM_W'(HALF_DEN);
  localparam logic signed [NUM_W-1:0] LIM_LO_C = NUM_W'(LIM_LO);
  localparam logic signed [NUM_W-1:0] LIM_HI_C = NUM_W'(LIM_HI);

  swlp_pkg::state_t state, state_next;

  // Sample memory: one synchronous read port, one write port.
  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       mem_we;
  logic [PTR_W-1:0]           ptr;
  logic                       full;

  logic [LA_W-1:0]            lookahead;
  logic signed [SAMPLE_W-1:0] y;
  logic signed [SY_W-1:0]     sy;
  logic signed [SXY_W-1:0]    sxy;
  logic signed [NUM_W-1:0]    prod_a;
  logic signed [NUM_W-1:0]    prod_b;
  logic signed [NUM_W-1:0]    prod_c;
  logic signed [N_W-1:0]      n;
  logic signed [NUM_W-1:0]    nt;
  logic signed [NUM_W-1:0]    numr;
  logic signed [PRED_W-1:0]   res;
  logic                       out_valid;
  logic signed [PRED_W-1:0]   out_pred;

  logic signed [SAMPLE_W-1:0] oldv;
  logic signed [SY_W-1:0]     rest;
  logic [T_W-1:0]             t_val;
  logic signed [N_W+T_W:0]    ntp;
  logic                       below;
  logic                       above;
  logic                       div_start;
  logic                       out_load;
  logic                       in_take;
  logic [U_W-1:0]             dividend;
  swlp_pkg::div_status_t      div_stat;

  assign in_take   = sample_ch.valid && sample_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Slots never written since reset read as zero.
  assign oldv  = full ? rd_data : '0;
  assign rest  = sy - SY_W'(oldv);
  assign t_val = T_W'(W + 1) + T_W'({lookahead, 1'b0});
  assign ntp   = n * $signed({1'b0, t_val});
  assign below = numr < LIM_LO_C;
  assign above = numr >= LIM_HI_C;
  // Offset so the quotient is unsigned: q = PRED_MIN + u / den.
  assign dividend = U_W'(numr - LIM_LO_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swlp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    sample_ch.ready = 1'b0;
    mem_we          = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state)
      swlp_pkg::S_IDLE: begin
        sample_ch.ready = 1'b1;
        if (sample_ch.valid) begin
          state_next = swlp_pkg::S_UPDATE;
        end
      end
      swlp_pkg::S_UPDATE: begin
        mem_we     = 1'b1;
        state_next = swlp_pkg::S_PROD;
      end
      swlp_pkg::S_PROD:  state_next = swlp_pkg::S_DIFF;
      swlp_pkg::S_DIFF:  state_next = swlp_pkg::S_SCALE;
      swlp_pkg::S_SCALE: state_next = swlp_pkg::S_SUM;
      swlp_pkg::S_SUM:   state_next = swlp_pkg::S_RANGE;
      swlp_pkg::S_RANGE: begin
        if (below || above) begin
          state_next = swlp_pkg::S_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = swlp_pkg::S_DIV;
        end
      end
      swlp_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_next = swlp_pkg::S_OUT;
        end
      end
      swlp_pkg::S_OUT: begin
        // Hold until the output register is free.
        if (!out_valid || pred_ch.ready) begin
          out_load   = 1'b1;
          state_next = swlp_pkg::S_IDLE;
        end
      end
      default: state_next = swlp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr] <= y;
    end
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      full      <= 1'b0;
      sy        <= '0;
      sxy       <= '0;
      lookahead <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        lookahead <= cfg_ch.lookahead;
      end
      if (mem_we) begin
        // Every kept sample moves one step toward the oldest end.
        sy  <= rest + SY_W'(y);
        sxy <= sxy - SXY_W'(rest) + WM1_C * SXY_W'(y);
        if (ptr == PTR_W'(WINDOW - 1)) begin
          ptr  <= '0;
          full <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pred_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      y <= sample_ch.sample;
    end
    case (state)
      swlp_pkg::S_PROD: begin
        prod_a <= NUM_W'(sxy) * W_C;
        prod_b <= NUM_W'(sy) * SX_C;
        prod_c <= NUM_W'(sy) * D2_C + HALF_C;
      end
      swlp_pkg::S_DIFF:  n    <= N_W'(prod_a - prod_b);
      swlp_pkg::S_SCALE: nt   <= NUM_W'(ntp);
      swlp_pkg::S_SUM:   numr <= nt * W_C + prod_c;
      swlp_pkg::S_RANGE: begin
        if (below) begin
          res <= swlp_pkg::PRED_MIN;
        end else if (above) begin
          res <= swlp_pkg::PRED_MAX;
        end
      end
      swlp_pkg::S_DIV: begin
        if (div_stat.done) begin
          res <= $signed(div_stat.quotient) + swlp_pkg::PRED_MIN;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_pred <= res;
    end
  end

  swlp_divider #(
    .DEN (DEN),
    .U_W (U_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .status   (div_stat)
  );

  assign pred_ch.valid      = out_valid;
  assign pred_ch.prediction = out_pred;

endmodule

// ===== hw/rtl/swlp_divider.sv =====
// Division by a constant through a reciprocal multiply: one registered product,
// quotient ready the cycle after start. Depends on swlp_pkg (PRED_W, div_status_t).
module swlp_divider #(
  parameter longint DEN = 1,
  parameter int     U_W = swlp_pkg::PRED_W + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [U_W-1:0]        dividend,
  output swlp_pkg::div_status_t status
);

  // floor(u / DEN) equals (u * RECIP) >> SHIFT for every u below 2**U_W when
  // RECIP = ceil(2**SHIFT / DEN) and SHIFT = U_W + clog2(DEN).
  localparam int Q_W   = swlp_pkg::PRED_W;
  localparam int SHIFT = U_W + $clog2(DEN);
  localparam int M_W   = U_W + 1;
  localparam int P_W   = U_W + M_W;

  localparam logic [127:0] M_WIDE =
    ((128'(1) << SHIFT) + 128'(DEN) - 128'(1)) / 128'(DEN);
  localparam logic [M_W-1:0] RECIP = M_W'(M_WIDE);

  logic           done;
  logic [P_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= P_W'(dividend) * P_W'(RECIP);
    end
  end

  assign status.done     = done;
  assign status.quotient = prod[SHIFT +: Q_W];

endmodule

// ===== hw/rtl/swlp_checker.sv =====
// Port-level checks for the sliding-window linear predictor, bound to the top.
// Depends on swlp_pkg and sliding_window_linear_predictor.
module swlp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [swlp_pkg::PRED_W-1:0]       out_pred
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pred))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result delivered with no request outstanding");

endmodule

bind sliding_window_linear_predictor swlp_checker u_swlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (pred_ch.valid),
  .out_ready (pred_ch.ready),
  .out_pred  (pred_ch.prediction)
);

// ===== tb/tb_sliding_window_linear_predictor.sv =====
// Self-checking testbench for the sliding-window linear predictor.
// Uses swlp_pkg and the channel interfaces from hw/rtl, and the top module.
// A directed table runs first, then random bursts over several lookahead settings.
module tb_sliding_window_linear_predictor;

  // Window geometry, fixed by the block's default parameter
  localparam longint W   = swlp_pkg::WINDOW_DEF;
  localparam longint SX  = W * (W - 1) / 2;
  localparam longint SXX = (W - 1) * W * (2 * W - 1) / 6;
  localparam longint D   = W * SXX - SX * SX;
  localparam longint DEN = 2 * W * D;

  // Idle time after a drain, well beyond the path of an in-range result
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 8;

  typedef struct {
    logic signed [swlp_pkg::SAMPLE_W-1:0]  smp;
    logic [swlp_pkg::LOOKAHEAD_W-1:0]      la;
    bit                                    typed;
    logic signed [swlp_pkg::PRED_W-1:0]    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  swlp_sample_if sample_ch ();
  swlp_cfg_if    cfg_ch ();
  swlp_pred_if   pred_ch ();

  sliding_window_linear_predictor DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .cfg_ch    (cfg_ch),
    .pred_ch   (pred_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's window, running sums and lookahead register
  longint                           fit_window [swlp_pkg::WINDOW_DEF];
  int                               fit_head;
  longint                           fit_sum_y;
  longint                           fit_sum_xy;
  logic [swlp_pkg::LOOKAHEAD_W-1:0] fit_lookahead;

  logic signed [swlp_pkg::PRED_W-1:0] predictions_due [$];

  int errors          = 0;
  int samples_sent    = 0;
  int preds_checked   = 0;
  int preds_saturated = 0;
  int la_writes       = 0;
  int cycle_count     = 0;

  // Shift one sample into the shadow window, refit the line and return its
  // value at x = WINDOW + lookahead, rounded half up and clamped to 18 bits.
  function automatic logic signed [swlp_pkg::PRED_W-1:0] slide_and_extrapolate(
    input logic signed [swlp_pkg::SAMPLE_W-1:0] y
  );
    longint yv, rest, slope_num, t, num, q;
    yv = longint'(y);
    rest = fit_sum_y - fit_window[fit_head];
    // every kept sample steps one x position toward the oldest end
    fit_sum_xy = fit_sum_xy - rest + (W - 1) * yv;
    fit_sum_y = rest + yv;
    fit_window[fit_head] = yv;
    fit_head = (fit_head == W - 1) ? 0 : fit_head + 1;
    slope_num = W * fit_sum_xy - SX * fit_sum_y;
    t = 2 * (W + longint'(fit_lookahead)) - (W - 1);
    num = 2 * fit_sum_y * D + W * slope_num * t + DEN / 2;
    // floor division; the native divide truncates toward zero
    q = num / DEN;
    if ((num % DEN) != 0 && num < 0) q = q - 1;
    if (q > swlp_pkg::PRED_MAX_VAL) q = swlp_pkg::PRED_MAX_VAL;
    if (q < swlp_pkg::PRED_MIN_VAL) q = swlp_pkg::PRED_MIN_VAL;
    return q[swlp_pkg::PRED_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 100)
      $display("[%0d] MISMATCH %s: got %0d expected %0d", cycle_count, what, got, want);
  endtask

  // Hold a sample request until the block takes it, then book its prediction.
  // Valid is not lowered here, so back-to-back requests keep it high.
  task automatic send_sample(input logic signed [swlp_pkg::SAMPLE_W-1:0] s,
                             input bit typed,
                             input logic signed [swlp_pkg::PRED_W-1:0] want);
    logic signed [swlp_pkg::PRED_W-1:0] predicted;
    @(negedge clk);
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = slide_and_extrapolate(s);
    predictions_due.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // Drop valid for a stretch set by n; scramble the payload so it is never trusted idle
  task automatic hold_off(input int n);
    @(negedge clk);
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= swlp_pkg::SAMPLE_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and wait for every booked prediction, then let the pipe settle
  task automatic drain_predictions();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (predictions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write lookahead only with the block idle
  task automatic write_lookahead(input logic [swlp_pkg::LOOKAHEAD_W-1:0] v);
    drain_predictions();
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.lookahead <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    fit_lookahead = v;
    la_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Compare each prediction taken by the sink against the oldest booking
  always @(posedge clk) begin
    if (!rst && pred_ch.valid && pred_ch.ready) begin
      if (predictions_due.size() == 0) begin
        report_mismatch("prediction with none outstanding", pred_ch.prediction, 0);
      end else begin
        if (pred_ch.prediction !== predictions_due[0])
          report_mismatch("prediction", pred_ch.prediction, predictions_due[0]);
        if (predictions_due[0] == swlp_pkg::PRED_MAX ||
            predictions_due[0] == swlp_pkg::PRED_MIN)
          preds_saturated++;
        void'(predictions_due.pop_front());
        preds_checked++;
      end
    end
  end

  // Sink back-pressure: switch among always ready, coin flip, long stalls
  // and strict alternation, each for a random stretch
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;
  bit toggle_rdy = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        pred_ch.ready <= 1'b1;
      end
      1: begin
        pred_ch.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          pred_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 40);
          pred_ch.ready <= 1'b0;
        end else begin
          pred_ch.ready <= 1'b1;
        end
      end
      default: begin
        toggle_rdy = ~toggle_rdy;
        pred_ch.ready <= toggle_rdy;
      end
    endcase
  end

  // Guard against a hang anywhere in the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d predictions outstanding",
               cycle_count, predictions_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed table. Row 0 is the all-zero window after reset. Eight copies of
  // the top value give a flat window, so the line is that constant. With the
  // largest lookahead a full exact rising ramp clamps high and a full exact
  // falling ramp clamps low. Rows in between go through the shadow model.
  stim_row_t directed_rows [25] = '{
    '{16'sd0,      6'd0,  1'b1, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b0, 18'sd0},
    '{16'sd32767,  6'd0,  1'b1, 18'sd32767},
    '{-16'sd32768, 6'd63, 1'b0, 18'sd0},
    '{-16'sd23406, 6'd63, 1'b0, 18'sd0},
    '{-16'sd14044, 6'd63, 1'b0, 18'sd0},
    '{-16'sd4682,  6'd63, 1'b0, 18'sd0},
    '{16'sd4680,   6'd63, 1'b0, 18'sd0},
    '{16'sd14042,  6'd63, 1'b0, 18'sd0},
    '{16'sd23404,  6'd63, 1'b0, 18'sd0},
    '{16'sd32766,  6'd63, 1'b1, swlp_pkg::PRED_MAX},
    '{16'sd32766,  6'd63, 1'b0, 18'sd0},
    '{16'sd23404,  6'd63, 1'b0, 18'sd0},
    '{16'sd14042,  6'd63, 1'b0, 18'sd0},
    '{16'sd4680,   6'd63, 1'b0, 18'sd0},
    '{-16'sd4682,  6'd63, 1'b0, 18'sd0},
    '{-16'sd14044, 6'd63, 1'b0, 18'sd0},
    '{-16'sd23406, 6'd63, 1'b0, 18'sd0},
    '{-16'sd32768, 6'd63, 1'b1, swlp_pkg::PRED_MIN}
  };

  logic [swlp_pkg::LOOKAHEAD_W-1:0] phase_lookahead [NUM_PHASES] = '{
    6'd63, 6'd0, 6'd1, 6'd0, 6'd31, 6'd0, 6'd63, 6'd32
  };

  initial begin
    logic signed [swlp_pkg::SAMPLE_W-1:0] s;
    logic [swlp_pkg::LOOKAHEAD_W-1:0]     la;
    longint                               pos, step;
    int                                   left, burst, shape;
    bit                                   paused;

    // Known values on every input from time zero
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.lookahead = '0;
    pred_ch.ready    = 1'b0;

    foreach (fit_window[i]) fit_window[i] = 0;
    fit_head      = 0;
    fit_sum_y     = 0;
    fit_sum_xy    = 0;
    fit_lookahead = '0;
    paused        = 1'b0;
    pos           = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; write lookahead only when a row asks for a new one
    foreach (directed_rows[r]) begin
      if (directed_rows[r].la != fit_lookahead) write_lookahead(directed_rows[r].la);
      send_sample(directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases, each under its own lookahead setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      la = (ph == 3 || ph == 5) ? 6'($urandom_range(0, 63)) : phase_lookahead[ph];
      write_lookahead(la);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        shape = $urandom_range(0, 9);
        step  = longint'($urandom_range(0, 1200)) - 600;
        for (int i = 0; i < burst; i++) begin
          // Mostly smooth tracks so large lookaheads land in range; the
          // rest is full-range noise, rail values and small jitter
          if (shape <= 5) begin
            pos = pos + step + longint'($urandom_range(0, 31)) - 16;
            if (pos > 32767 || pos < -32768) begin
              pos  = (pos > 32767) ? 32767 : -32768;
              step = -step;
            end
          end else if (shape == 6) begin
            pos = longint'($urandom_range(0, 65535)) - 32768;
          end else if (shape == 7) begin
            case ($urandom_range(0, 3))
              0: pos = 32767;
              1: pos = -32768;
              2: pos = 0;
              default: pos = -1;
            endcase
          end else begin
            pos = longint'($urandom_range(0, 127)) - 64;
          end
          s = pos[swlp_pkg::SAMPLE_W-1:0];
          send_sample(s, 1'b0, '0);
        end
        left -= burst;
        // Once mid-run, stop and let every prediction come back
        if (ph == 3 && !paused && left < PHASE_ITEMS / 2) begin
          drain_predictions();
          paused = 1'b1;
        end else if ($urandom_range(0, 2) != 0) begin
          hold_off($urandom_range(1, 12));
        end
      end
    end

    // Wait out the last predictions, then watch for strays
    drain_predictions();

    $display("Sent %0d samples across %0d lookahead writes (0, 1, 31, 32, 63 and random).",
             samples_sent, la_writes);
    $display("Checked %0d predictions, %0d of them clamped at a rail; %0d mismatches.",
             preds_checked, preds_saturated, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sliding_window_linear_predictor.f =====
hw/rtl/swlp_pkg.sv
hw/rtl/swlp_channels.sv
hw/rtl/swlp_divider.sv
hw/rtl/sliding_window_linear_predictor.sv
hw/rtl/swlp_checker.sv
tb/tb_sliding_window_linear_predictor.sv
